@@ design/bce_pkg.sv @@
package bce_pkg;

  // Arithmetic sizing
  localparam int WEIGHT_BITS = 18;
  localparam int DW          = 32;                  // corner / coordinate width
  localparam int NUM_W       = DW + 1;              // exact difference width
  localparam int LIM_EXP     = 15 + WEIGHT_BITS;    // local coordinate clamp exponent
  localparam int QB          = LIM_EXP + 1;         // quotient bits produced by the divider
  localparam int DV_W        = NUM_W + WEIGHT_BITS + 1;
  localparam int TOP_W       = DV_W - QB;           // dividend bits above the quotient
  localparam int XI_W        = QB + 1;              // signed local coordinate / factor
  localparam int PP_W        = 2 * XI_W;            // exact factor product
  localparam int WT_W        = PP_W - WEIGHT_BITS;  // rounded weight
  localparam int TM_W        = WT_W + DW;           // weight times corner
  localparam int SUM_W       = TM_W + 2;            // sum of four terms
  localparam int RND_W       = SUM_W - WEIGHT_BITS; // rounded sum

  typedef struct packed {
    logic signed [DW-1:0] point_x;
    logic signed [DW-1:0] point_y;
    logic signed [DW-1:0] cell_x_low;
    logic signed [DW-1:0] cell_x_high;
    logic signed [DW-1:0] cell_y_low;
    logic signed [DW-1:0] cell_y_high;
    logic signed [DW-1:0] corner_value_00;
    logic signed [DW-1:0] corner_value_10;
    logic signed [DW-1:0] corner_value_01;
    logic signed [DW-1:0] corner_value_11;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] surface_value;
    logic                 cell_error;
  } out_item_t;

endpackage

@@ design/bilinear_cell_evaluator_top.sv @@
// Bilinear cell evaluator. One query transfer is taken on every clock where start is high;
// busy stays low, so a new point may be issued each cycle. Each result appears on out_data
// with out_valid high for exactly one cycle, in issue order. The receiver cannot stall
// the block. The pipeline holds the restoring dividers for xi and eta, which resolve one
// quotient bit per pipeline stage (34 stages), followed by split-multiplier stages for
// the weights and the weighted corner sum.
module bilinear_cell_evaluator_top
  import bce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int LAT = QB + 13;
  localparam int XL  = XI_W / 2;
  localparam int XH  = XI_W - XL;
  localparam int WL  = WT_W / 2;
  localparam int WH  = WT_W - WL;

  localparam logic [QB-1:0]          COORD_LIM = {1'b1, {LIM_EXP{1'b0}}};
  localparam logic signed [XI_W-1:0] XI_MAX    = $signed({1'b0, COORD_LIM});
  localparam logic signed [XI_W-1:0] XI_MIN    = -XI_MAX;
  localparam logic signed [XI_W-1:0] W_ONE     = XI_W'(1) <<< WEIGHT_BITS;
  localparam logic signed [PP_W-1:0] HALF_PP   = PP_W'(1) <<< (WEIGHT_BITS - 1);
  localparam logic signed [SUM_W-1:0] HALF_S   = SUM_W'(1) <<< (WEIGHT_BITS - 1);

  typedef struct packed {
    logic [3:0][DW-1:0] corner;
    logic               err;
  } carry_t;

  typedef struct packed {
    logic [NUM_W-1:0] mag;
    logic [DW-1:0]    den;
    logic             neg;
  } abs_lane_t;

  typedef struct packed {
    logic [DV_W-1:0] dvd;
    logic [DW-1:0]   den;
    logic            neg;
  } dvd_lane_t;

  typedef struct packed {
    logic [DW-1:0] den;
    logic [DW-1:0] rem;
    logic [QB-1:0] acc;
    logic          neg;
    logic          ovf;
  } div_lane_t;

  typedef struct packed {
    logic signed [2*XL+1:0]  ll;
    logic signed [XL+XH:0]   lh;
    logic signed [XL+XH:0]   hl;
    logic signed [2*XH-1:0]  hh;
  } wpp_t;

  // One restoring division step: one quotient bit
  function automatic div_lane_t div_step(input div_lane_t s);
    div_lane_t  o;
    logic [DW:0] t;
    logic        ge;
    o   = s;
    t   = {s.rem, s.acc[QB-1]};
    ge  = (t >= {1'b0, s.den});
    o.rem = ge ? DW'(t - {1'b0, s.den}) : t[DW-1:0];
    o.acc = {s.acc[QB-2:0], ge};
    return o;
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 0: exact differences
  logic                          s0_vld_r;
  logic [1:0][NUM_W-1:0]         s0_num_r;
  logic [1:0][NUM_W-1:0]         s0_den_r;
  logic [3:0][DW-1:0]            s0_corner_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
    s0_num_r[0]    <= NUM_W'(in_data.point_x) - NUM_W'(in_data.cell_x_low);
    s0_num_r[1]    <= NUM_W'(in_data.point_y) - NUM_W'(in_data.cell_y_low);
    s0_den_r[0]    <= NUM_W'(in_data.cell_x_high) - NUM_W'(in_data.cell_x_low);
    s0_den_r[1]    <= NUM_W'(in_data.cell_y_high) - NUM_W'(in_data.cell_y_low);
    s0_corner_r[0] <= in_data.corner_value_00;
    s0_corner_r[1] <= in_data.corner_value_10;
    s0_corner_r[2] <= in_data.corner_value_01;
    s0_corner_r[3] <= in_data.corner_value_11;
  end

  // Stage 1: magnitude of the numerator, empty cell check
  logic            s1_vld_r;
  abs_lane_t [1:0] s1_lane_r, s1_lane_nxt;
  carry_t          s1_car_r, s1_car_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s1_lane_nxt[l].neg = s0_num_r[l][NUM_W-1];
      s1_lane_nxt[l].mag = s0_num_r[l][NUM_W-1] ? NUM_W'(-s0_num_r[l]) : s0_num_r[l];
      s1_lane_nxt[l].den = s0_den_r[l][DW-1:0];
    end
    s1_car_nxt.corner = s0_corner_r;
    s1_car_nxt.err    = s0_den_r[0][NUM_W-1] || (s0_den_r[0] == '0) ||
                        s0_den_r[1][NUM_W-1] || (s0_den_r[1] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
    s1_lane_r <= s1_lane_nxt;
    s1_car_r  <= s1_car_nxt;
  end

  // Stage 2: scaled dividend, ceiling bias for negative numerators
  logic            s2_vld_r;
  dvd_lane_t [1:0] s2_lane_r, s2_lane_nxt;
  carry_t          s2_car_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s2_lane_nxt[l].dvd = DV_W'({s1_lane_r[l].mag, {WEIGHT_BITS{1'b0}}}) +
                           (s1_lane_r[l].neg ? (DV_W'(s1_lane_r[l].den) - DV_W'(1))
                                             : DV_W'(0));
      s2_lane_nxt[l].den = s1_lane_r[l].den;
      s2_lane_nxt[l].neg = s1_lane_r[l].neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_lane_r <= s2_lane_nxt;
    s2_car_r  <= s1_car_r;
  end

  // Divider chain: entry 0 loads, entries 1..QB each resolve one quotient bit
  logic      dv_vld_r  [QB+1];
  div_lane_t dv_lane_r [QB+1][2];
  carry_t    dv_car_r  [QB+1];
  div_lane_t dv_init_nxt [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dv_init_nxt[l].den = s2_lane_r[l].den;
      dv_init_nxt[l].neg = s2_lane_r[l].neg;
      dv_init_nxt[l].rem = DW'(s2_lane_r[l].dvd[DV_W-1:QB]);
      dv_init_nxt[l].acc = s2_lane_r[l].dvd[QB-1:0];
      // quotient would not fit in QB bits: clamp later
      dv_init_nxt[l].ovf = (DW'(s2_lane_r[l].dvd[DV_W-1:QB]) >= s2_lane_r[l].den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) begin
        dv_vld_r[k] <= 1'b0;
      end
    end else begin
      dv_vld_r[0] <= s2_vld_r;
      for (int k = 0; k < QB; k++) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end
    dv_car_r[0]     <= s2_car_r;
    dv_lane_r[0][0] <= dv_init_nxt[0];
    dv_lane_r[0][1] <= dv_init_nxt[1];
    for (int k = 0; k < QB; k++) begin
      dv_car_r[k+1]     <= dv_car_r[k];
      dv_lane_r[k+1][0] <= div_step(dv_lane_r[k][0]);
      dv_lane_r[k+1][1] <= div_step(dv_lane_r[k][1]);
    end
  end

  // Stage Q: clamp and sign the local coordinates
  logic                  q_vld_r;
  logic signed [XI_W-1:0] q_r [2];
  logic signed [XI_W-1:0] q_nxt [2];
  carry_t                q_car_r;

  always_comb begin
    logic [QB-1:0] mag;
    for (int l = 0; l < 2; l++) begin
      mag = (dv_lane_r[QB][l].ovf || (dv_lane_r[QB][l].acc > COORD_LIM)) ?
            COORD_LIM : dv_lane_r[QB][l].acc;
      q_nxt[l] = dv_lane_r[QB][l].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= dv_vld_r[QB];
    end
    q_r[0]  <= q_nxt[0];
    q_r[1]  <= q_nxt[1];
    q_car_r <= dv_car_r[QB];
  end

  // Stage F: factors 1-xi, xi, 1-eta, eta
  logic                   f_vld_r;
  logic signed [XI_W-1:0] fac_r [4];
  carry_t                 f_car_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= q_vld_r;
    end
    fac_r[0] <= W_ONE - q_r[0];
    fac_r[1] <= q_r[0];
    fac_r[2] <= W_ONE - q_r[1];
    fac_r[3] <= q_r[1];
    f_car_r  <= q_car_r;
  end

  // Stage M1: weight partial products, factors split in halves
  logic   m1_vld_r;
  wpp_t   m1_pp_r [4];
  wpp_t   m1_pp_nxt [4];
  carry_t m1_car_r;

  always_comb begin
    logic signed [XI_W-1:0] fa [4];
    logic signed [XI_W-1:0] fb [4];
    fa[0] = fac_r[0]; fb[0] = fac_r[2];
    fa[1] = fac_r[1]; fb[1] = fac_r[2];
    fa[2] = fac_r[0]; fb[2] = fac_r[3];
    fa[3] = fac_r[1]; fb[3] = fac_r[3];
    for (int j = 0; j < 4; j++) begin
      m1_pp_nxt[j].ll = $signed({1'b0, fa[j][XL-1:0]}) * $signed({1'b0, fb[j][XL-1:0]});
      m1_pp_nxt[j].lh = $signed({1'b0, fa[j][XL-1:0]}) * $signed(fb[j][XI_W-1:XL]);
      m1_pp_nxt[j].hl = $signed(fa[j][XI_W-1:XL]) * $signed({1'b0, fb[j][XL-1:0]});
      m1_pp_nxt[j].hh = $signed(fa[j][XI_W-1:XL]) * $signed(fb[j][XI_W-1:XL]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= f_vld_r;
    end
    for (int j = 0; j < 4; j++) begin
      m1_pp_r[j] <= m1_pp_nxt[j];
    end
    m1_car_r <= f_car_r;
  end

  // Stage M2: combine partials and round each weight
  logic                   m2_vld_r;
  logic signed [WT_W-1:0] m2_w_r [4];
  logic signed [WT_W-1:0] m2_w_nxt [4];
  carry_t                 m2_car_r;

  always_comb begin
    logic signed [PP_W-1:0] p;
    for (int j = 0; j < 4; j++) begin
      p = PP_W'($signed(m1_pp_r[j].ll)) +
          (PP_W'($signed(m1_pp_r[j].lh)) <<< XL) +
          (PP_W'($signed(m1_pp_r[j].hl)) <<< XL) +
          (PP_W'($signed(m1_pp_r[j].hh)) <<< (2 * XL)) + HALF_PP;
      m2_w_nxt[j] = p[PP_W-1:WEIGHT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else begin
      m2_vld_r <= m1_vld_r;
    end
    for (int j = 0; j < 4; j++) begin
      m2_w_r[j] <= m2_w_nxt[j];
    end
    m2_car_r <= m1_car_r;
  end

  // Stage M3: weight times corner, weight split in halves
  logic                       m3_vld_r;
  logic signed [WL+DW:0]      m3_pl_r [4];
  logic signed [WH+DW-1:0]    m3_ph_r [4];
  logic                       m3_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else begin
      m3_vld_r <= m2_vld_r;
    end
    for (int j = 0; j < 4; j++) begin
      m3_pl_r[j] <= $signed({1'b0, m2_w_r[j][WL-1:0]}) * $signed(m2_car_r.corner[j]);
      m3_ph_r[j] <= $signed(m2_w_r[j][WT_W-1:WL]) * $signed(m2_car_r.corner[j]);
    end
    m3_err_r <= m2_car_r.err;
  end

  // Stage M4: full weighted terms
  logic                   m4_vld_r;
  logic signed [TM_W-1:0] m4_t_r [4];
  logic                   m4_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_vld_r <= 1'b0;
    end else begin
      m4_vld_r <= m3_vld_r;
    end
    for (int j = 0; j < 4; j++) begin
      m4_t_r[j] <= TM_W'(m3_pl_r[j]) + (TM_W'(m3_ph_r[j]) <<< WL);
    end
    m4_err_r <= m3_err_r;
  end

  // Stage A1: pairwise sums
  logic                     a1_vld_r;
  logic signed [TM_W:0]     a1_s_r [2];
  logic                     a1_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_vld_r <= 1'b0;
    end else begin
      a1_vld_r <= m4_vld_r;
    end
    a1_s_r[0] <= (TM_W+1)'(m4_t_r[0]) + (TM_W+1)'(m4_t_r[1]);
    a1_s_r[1] <= (TM_W+1)'(m4_t_r[2]) + (TM_W+1)'(m4_t_r[3]);
    a1_err_r  <= m4_err_r;
  end

  // Stage A2: total plus rounding half
  logic                    a2_vld_r;
  logic signed [SUM_W-1:0] a2_sum_r;
  logic                    a2_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a2_vld_r <= 1'b0;
    end else begin
      a2_vld_r <= a1_vld_r;
    end
    a2_sum_r <= SUM_W'(a1_s_r[0]) + SUM_W'(a1_s_r[1]) + HALF_S;
    a2_err_r <= a1_err_r;
  end

  // Output stage: round, saturate, empty cell override
  out_item_t out_nxt;

  always_comb begin
    logic [RND_W-1:0] rnd;
    logic [RND_W-DW:0] top;
    rnd = a2_sum_r[SUM_W-1:WEIGHT_BITS];
    top = rnd[RND_W-1:DW-1];
    if (a2_err_r) begin
      out_nxt.surface_value = '0;
    end else if ((&top) || !(|top)) begin
      out_nxt.surface_value = rnd[DW-1:0];
    end else if (rnd[RND_W-1]) begin
      out_nxt.surface_value = {1'b1, {(DW-1){1'b0}}};
    end else begin
      out_nxt.surface_value = {1'b0, {(DW-1){1'b1}}};
    end
    out_nxt.cell_error = a2_err_r;
  end

  logic      out_vld_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= a2_vld_r;
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching start transfer");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.cell_error) |-> (out_data.surface_value == '0))
    else $error("empty cell result not zero");

  a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[QB] |-> (dv_lane_r[QB][0].ovf || (dv_lane_r[QB][0].rem < dv_lane_r[QB][0].den)))
    else $error("x divider remainder out of range");

  a_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[QB] |-> (dv_lane_r[QB][1].ovf || (dv_lane_r[QB][1].rem < dv_lane_r[QB][1].den)))
    else $error("y divider remainder out of range");

  a_xi_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_vld_r |-> ((q_r[0] <= XI_MAX) && (q_r[0] >= XI_MIN) &&
                 (q_r[1] <= XI_MAX) && (q_r[1] >= XI_MIN)))
    else $error("local coordinate outside clamp range");

endmodule

@@ tb/tb.sv @@
module tb;
  import bce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WB      = WEIGHT_BITS;
  localparam int LATENCY = 47;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  in_item_t  pending_points[$];
  out_item_t expected_surface[$];
  int        error_count = 0;
  int        gap_left = 0;
  bit        hold_for_drain = 1'b0;

  bilinear_cell_evaluator_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // floor(num * 2^WB / den), clamped to +-2^(15+WB)
  function automatic logic signed [63:0] local_coord(logic signed [63:0] num,
                                                     logic signed [63:0] den);
    logic [63:0] lim;
    logic [63:0] mag;
    logic [63:0] q;
    lim = 64'd1 << (15 + WB);
    mag = (num < 0 ? -num : num) << WB;
    q = (num < 0) ? (mag + den - 1) / den : mag / den;
    if (q > lim) q = lim;
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  // product rounded to WB fraction bits, add half then floor
  function automatic logic signed [127:0] round_wb(logic signed [127:0] v);
    return (v + (128'sd1 <<< (WB - 1))) >>> WB;
  endfunction

  function automatic out_item_t predict_surface(in_item_t it);
    logic signed [63:0]  wdt, hgt, one, xi, eta;
    logic signed [127:0] w00, w10, w01, w11, acc;
    out_item_t r;
    wdt = 64'(it.cell_x_high) - 64'(it.cell_x_low);
    hgt = 64'(it.cell_y_high) - 64'(it.cell_y_low);
    r = '0;
    if (wdt <= 0 || hgt <= 0) begin
      r.cell_error = 1'b1;
      return r;
    end
    one = 64'sd1 <<< WB;
    xi  = local_coord(64'(it.point_x) - 64'(it.cell_x_low), wdt);
    eta = local_coord(64'(it.point_y) - 64'(it.cell_y_low), hgt);
    w00 = round_wb(128'(one - xi) * 128'(one - eta));
    w10 = round_wb(128'(xi) * 128'(one - eta));
    w01 = round_wb(128'(one - xi) * 128'(eta));
    w11 = round_wb(128'(xi) * 128'(eta));
    acc = w00 * 128'(it.corner_value_00) + w10 * 128'(it.corner_value_10)
        + w01 * 128'(it.corner_value_01) + w11 * 128'(it.corner_value_11);
    acc = round_wb(acc);
    if (acc > 128'sd2147483647) r.surface_value = 32'h7FFFFFFF;
    else if (acc < -128'sd2147483648) r.surface_value = 32'h80000000;
    else r.surface_value = acc[31:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] edges[6];
    edges = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h1, 32'h00010000};
    case ($urandom_range(3))
      0: return edges[$urandom_range(5)];
      1: return $urandom;
      default: return $signed($urandom_range(65536 * 40)) - 32'sd1310720;
    endcase
  endfunction

  // mostly a well-formed cell with the point inside or near it, sometimes a fully random one
  function automatic in_item_t rand_point();
    in_item_t it;
    logic [31:0] w, h;
    it.corner_value_00 = rand_coord();
    it.corner_value_10 = rand_coord();
    it.corner_value_01 = rand_coord();
    it.corner_value_11 = rand_coord();
    if ($urandom_range(9) == 0) begin
      it.point_x = $urandom; it.point_y = $urandom;
      it.cell_x_low = rand_coord(); it.cell_x_high = rand_coord();
      it.cell_y_low = rand_coord(); it.cell_y_high = rand_coord();
      return it;
    end
    w = ($urandom_range(7) == 0) ? $urandom_range(4, 1) : $urandom_range(1 << 20, 1);
    h = ($urandom_range(7) == 0) ? $urandom_range(4, 1) : $urandom_range(1 << 20, 1);
    it.cell_x_low  = $signed($urandom) >>> $urandom_range(12);
    it.cell_y_low  = $signed($urandom) >>> $urandom_range(12);
    it.cell_x_high = it.cell_x_low + w;
    it.cell_y_high = it.cell_y_low + h;
    it.point_x = it.cell_x_low + $signed($urandom_range(w + w / 4)) - $signed(w / 8);
    it.point_y = it.cell_y_low + $signed($urandom_range(h + h / 4)) - $signed(h / 8);
    return it;
  endfunction

  // driver: falling-edge launch, transfer when start && !busy at rising edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_surface.push_back(predict_surface(in_data));
        void'(pending_points.pop_front());
        gap_left = pick_gap();
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (hold_for_drain && expected_surface.size() != 0) begin
          start <= 1'b0;
        end else if (pending_points.size() != 0) begin
          hold_for_drain = 1'b0;
          start   <= 1'b1;
          in_data <= pending_points[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_surface.size() == 0) begin
        $display("%0t: unexpected result value=%h err=%b", $realtime,
                 out_data.surface_value, out_data.cell_error);
        error_count++;
      end else begin
        exp_r = expected_surface.pop_front();
        if (exp_r.surface_value !== out_data.surface_value) begin
          $display("%0t: surface_value expected %h actual %h", $realtime,
                   exp_r.surface_value, out_data.surface_value);
          error_count++;
        end
        if (exp_r.cell_error !== out_data.cell_error) begin
          $display("%0t: cell_error expected %b actual %b", $realtime,
                   exp_r.cell_error, out_data.cell_error);
          error_count++;
        end
      end
    end
  end

  initial begin
    in_item_t it;
    // directed: extremes, empty cells, far extrapolation, saturation
    it = '{32'h00008000, 32'h00008000, 0, 32'h00010000, 0, 32'h00010000,
           32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000};
    pending_points.push_back(it);
    it.cell_x_high = 0;                                     // zero width
    pending_points.push_back(it);
    it.cell_x_high = 32'h00010000; it.cell_y_high = 32'hFFFF0000; // negative height
    pending_points.push_back(it);
    it = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
           32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
    pending_points.push_back(it);
    it = '{32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1, 0, 1,
           32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF};
    pending_points.push_back(it);                           // clamp, saturate
    it = '{32'h80000000, 32'h80000000, 32'h7FFFFFFE, 32'h7FFFFFFF, 32'h7FFFFFFE,
           32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
    pending_points.push_back(it);
    it = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'h7FFFFFFE,
           32'h7FFFFFFF, 32'h12345678, 32'hFFFFFFFF, 32'h00000001, 32'h80000000};
    pending_points.push_back(it);
    it = '{0, 0, 0, 32'h00010000, 0, 32'h00010000, 32'hFFFFFFFF, 0, 0, 32'h7FFFFFFF};
    pending_points.push_back(it);
    it = '{32'h00010000, 32'h00010000, 0, 32'h00010000, 0, 32'h00010000, 0, 0, 0,
           32'h80000000};
    pending_points.push_back(it);
    it = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 1, 1, 1, 1};
    pending_points.push_back(it);
    repeat (6) pending_points.push_back(rand_point());
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_points.size() == 0);
    // hold the sender until everything in flight has drained
    hold_for_drain = 1'b1;
    repeat (1900) pending_points.push_back(rand_point());
    wait (pending_points.size() == 0);
    @(posedge clk);
    wait (expected_surface.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ files.f @@
design/bce_pkg.sv
design/bilinear_cell_evaluator_top.sv
tb/tb.sv
